### design/bf3zp_pkg.sv
// Shared constants for the 3x3 zero-padded box filter.
package bf3zp_pkg;

    localparam int DEFAULT_MAX_SIZE = 4096;

    localparam int PIXEL_W  = 8;
    localparam int SIZE_W   = 13;
    localparam int WEIGHT_W = 15;
    localparam int SUM_W    = 12;   // nine 8-bit pixels, at most 2295
    localparam int FRAC_W   = 15;   // Q0.15 weight
    localparam int CFG_W    = 15;   // widest register
    localparam int CFG_IDX_W = 1;

    localparam logic [SIZE_W-1:0]   SIZE_RESET   = 13'd64;
    localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 15'd3641;
    localparam int                  MIN_SIZE     = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_SIZE = 1'b0,
        REG_TAP_WEIGHT = 1'b1
    } cfg_reg_t;

endpackage

### design/box_filter_3x3_zero_pad_top.sv
// 3x3 box filter with zero padding over a streamed square grey image.
//
// Usage:
//   Input stream s_*: one 8-bit pixel per item in raster order, tuser set
//   marks a drain item (no pixel). After the image_size^2 pixels, send
//   image_size+1 drain items to flush the last row and column of outputs.
//   Output stream m_*: one filtered pixel per item, tlast on the last one
//   of the frame. The result for pixel (r,c) is produced by the item at
//   raster position (r+1,c+1).
//   Config port: cfg_we/cfg_addr/cfg_wdata, write only; use it only while idle,
//   the block does not check. Writing image_size restarts the frame position.
// Timing:
//   One item per cycle sustained unless m_tready stalls the output. An item
//   passes stage 1 (line store read), stage 2 (window sum) and the output
//   register (weight multiply) in that order. One line store read and one write
//   per item, at different columns except across a frame wrap, hold that rate.
// Reset: position counters and window clear; registers take 64 and 3641.
//   Line stores are not cleared; rows above the frame are masked to zero.
// Stall: when m_tready is low the output register holds its item; the
//   inner stages keep accepting until every stage is full.
module box_filter_3x3_zero_pad_top #(
    parameter int MAX_SIZE = bf3zp_pkg::DEFAULT_MAX_SIZE
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // configuration
    input  logic                            cfg_we,
    input  logic [bf3zp_pkg::CFG_IDX_W-1:0] cfg_addr,
    input  logic [bf3zp_pkg::CFG_W-1:0]     cfg_wdata,
    // input stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [7:0]                      s_tdata,    // [7:0] pixel
    input  logic                            s_tuser,    // [0] drain
    // output stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [7:0]                      m_tdata,    // [7:0] value
    output logic                            m_tlast
);

    localparam int COL_W = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
    localparam int SZ_W  = $clog2(MAX_SIZE + 2);   // holds size + 1
    localparam int PW    = bf3zp_pkg::PIXEL_W;
    localparam int SUM_W = bf3zp_pkg::SUM_W;
    localparam int FRAC_W = bf3zp_pkg::FRAC_W;
    localparam int PROD_W = SUM_W + bf3zp_pkg::WEIGHT_W;

    typedef logic [PW-1:0] pix_t;
    typedef pix_t col3_t [3];   // top, mid, bottom

    // Per-item control carried from the position logic to the window stage.
    typedef struct packed {
        logic top_en;
        logic mid_en;
        logic col0;
        logic col1;
        logic emit;
        logic last;
    } s1_ctl_t;

    // ---------------- configuration ----------------
    logic [bf3zp_pkg::SIZE_W-1:0]   size_reg;
    logic [bf3zp_pkg::WEIGHT_W-1:0] weight_reg;

    // ---------------- handshake / stage control ----------------
    logic adv1, adv2, adv3, accept, s1_fire;

    logic        s1_valid_reg;
    s1_ctl_t     s1_ctl_reg;
    logic [COL_W-1:0] s1_col_reg;
    pix_t        s1_pix_reg;
    logic [2*PW-1:0] rd_data_reg;   // {row two above, row one above}

    logic             s2_valid_reg;
    logic [SUM_W-1:0] s2_sum_reg;
    logic             s2_last_reg;

    logic       out_valid_reg;
    pix_t       out_value_reg;
    logic       out_last_reg;

    // ---------------- position ----------------
    logic [SZ_W-1:0]  row_reg, row_next;
    logic [COL_W-1:0] col_reg, col_next;
    logic [SZ_W-1:0]  eff_size, size_p1, r_cur, col_ext;
    logic [COL_W-1:0] c_cur;
    logic             restart;
    s1_ctl_t          ctl_cur;
    pix_t             bot_cur;

    // line store: low byte = row one above, high byte = row two above
    logic [2*PW-1:0] line_mem [MAX_SIZE];

    // ---------------- window ----------------
    col3_t win1_reg, win2_reg, col_new;
    logic [SUM_W-1:0] sum_cur;
    logic [PROD_W-1:0] prod;
    logic [PROD_W-FRAC_W-1:0] scaled;

    assign adv3     = !out_valid_reg || m_tready;
    assign adv2     = !s2_valid_reg || adv3;
    assign adv1     = !s1_valid_reg || adv2;
    assign s_tready = adv1;
    assign accept   = s_tvalid && adv1;
    assign s1_fire  = s1_valid_reg && adv2;

    // Clamp the size register to the supported range.
    always_comb
    begin
        if (int'(size_reg) < bf3zp_pkg::MIN_SIZE)
            eff_size = SZ_W'(bf3zp_pkg::MIN_SIZE);
        else if (int'(size_reg) > MAX_SIZE)
            eff_size = SZ_W'(MAX_SIZE);
        else
            eff_size = SZ_W'(size_reg);
    end
    assign size_p1 = eff_size + SZ_W'(1);

    // Current item position, flags and next position.
    always_comb
    begin
        restart = (SZ_W'(col_reg) >= eff_size) || (row_reg > size_p1) ||
                  ((row_reg == size_p1) && (col_reg != '0));
        r_cur   = restart ? '0 : row_reg;
        c_cur   = restart ? '0 : col_reg;
        col_ext = SZ_W'(c_cur);

        ctl_cur.top_en = (r_cur >= SZ_W'(2));
        ctl_cur.mid_en = (r_cur >= SZ_W'(1));
        ctl_cur.col0   = (c_cur == '0);
        ctl_cur.col1   = (c_cur == COL_W'(1));
        ctl_cur.last   = (r_cur == size_p1) && (c_cur == '0);
        ctl_cur.emit   = ((r_cur == SZ_W'(1)) && (c_cur != '0)) ||
                         ((r_cur >= SZ_W'(2)) && (r_cur <= eff_size)) ||
                         ctl_cur.last;
        bot_cur = (!s_tuser && (r_cur < eff_size)) ? s_tdata : '0;

        if (ctl_cur.last)
        begin
            row_next = '0;
            col_next = '0;
        end
        else if (col_ext + SZ_W'(1) >= eff_size)
        begin
            row_next = r_cur + SZ_W'(1);
            col_next = '0;
        end
        else
        begin
            row_next = r_cur;
            col_next = c_cur + COL_W'(1);
        end
    end

    // Config registers and position counters; a size write restarts the frame.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg   <= bf3zp_pkg::SIZE_RESET;
            weight_reg <= bf3zp_pkg::WEIGHT_RESET;
            row_reg    <= '0;
            col_reg    <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (bf3zp_pkg::cfg_reg_t'(cfg_addr))
                    bf3zp_pkg::REG_IMAGE_SIZE:
                        size_reg <= cfg_wdata[bf3zp_pkg::SIZE_W-1:0];
                    bf3zp_pkg::REG_TAP_WEIGHT:
                        weight_reg <= cfg_wdata[bf3zp_pkg::WEIGHT_W-1:0];
                    default: ;
                endcase
            end
            if (cfg_we && (bf3zp_pkg::cfg_reg_t'(cfg_addr) == bf3zp_pkg::REG_IMAGE_SIZE))
            begin
                row_reg <= '0;
                col_reg <= '0;
            end
            else if (accept)
            begin
                row_reg <= row_next;
                col_reg <= col_next;
            end
        end
    end

    // Line store: read at the incoming column, written back by the window stage.
    // Consecutive items use different columns except across a frame wrap,
    // where the new row-zero item masks both rows above.
    always_ff @(posedge clk)
    begin
        if (accept)
            rd_data_reg <= line_mem[c_cur];
        if (s1_fire)
            line_mem[s1_col_reg] <= {col_new[1], col_new[2]};
    end

    // Stage 1 payload.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_ctl_reg <= ctl_cur;
            s1_col_reg <= c_cur;
            s1_pix_reg <= bot_cur;
        end
    end

    // New column and window sum.
    always_comb
    begin
        col_new[0] = s1_ctl_reg.top_en ? rd_data_reg[2*PW-1:PW] : '0;
        col_new[1] = s1_ctl_reg.mid_en ? rd_data_reg[PW-1:0] : '0;
        col_new[2] = s1_pix_reg;
        sum_cur = '0;
        for (int k = 0; k < 3; k++)
        begin
            if (!s1_ctl_reg.col1)
                sum_cur = sum_cur + SUM_W'(win1_reg[k]);
            sum_cur = sum_cur + SUM_W'(win2_reg[k]);
            if (!s1_ctl_reg.col0)
                sum_cur = sum_cur + SUM_W'(col_new[k]);
        end
    end

    // Window columns: win1 is two columns back, win2 one column back.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < 3; k++)
            begin
                win1_reg[k] <= '0;
                win2_reg[k] <= '0;
            end
        end
        else if (s1_fire)
        begin
            win1_reg <= win2_reg;
            win2_reg <= col_new;
        end
    end

    // Stage 2 payload.
    always_ff @(posedge clk)
    begin
        if (adv2)
        begin
            s2_sum_reg  <= sum_cur;
            s2_last_reg <= s1_ctl_reg.last;
        end
    end

    // Weight, truncate, saturate.
    assign prod   = PROD_W'(s2_sum_reg) * PROD_W'(weight_reg);
    assign scaled = prod[PROD_W-1:FRAC_W];

    always_ff @(posedge clk)
    begin
        if (adv3)
        begin
            out_value_reg <= (scaled > 12'(255)) ? 8'd255 : scaled[PW-1:0];
            out_last_reg  <= s2_last_reg;
        end
    end

    // Stage valids.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv1)
                s1_valid_reg <= s_tvalid;
            if (adv2)
                s2_valid_reg <= s1_valid_reg && s1_ctl_reg.emit;
            if (adv3)
                out_valid_reg <= s2_valid_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_value_reg;
    assign m_tlast  = out_last_reg;

    // ---------------- assertions ----------------
    // An empty output register never blocks the input side.
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> s_tready)
        else $error("input stalled with empty output register");

    // Position counters stay inside the frame plus the drain rows.
    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ((SZ_W'(col_reg) < eff_size) && (row_reg <= size_p1)))
        else $error("position counter out of range");

    // A ready cycle with no input leaves the window stage empty.
    a_bubble: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tready && !s_tvalid) |=> !s1_valid_reg)
        else $error("window stage valid without an accepted item");

endmodule

### tb/box_filter_3x3_zero_pad_top_test.sv
// Self-checking testbench for the 3x3 zero-padded box filter top level.
`timescale 1ns / 1ps

module box_filter_3x3_zero_pad_top_test;

    typedef logic [bf3zp_pkg::PIXEL_W-1:0] pix_t;
    typedef logic [bf3zp_pkg::CFG_W-1:0]   cfg_word_t;

    // Directed plan: a row either writes a register or sends one item.
    typedef enum logic [1:0] {
        ROW_CFG,
        ROW_ITEM
    } plan_kind_t;

    // How a directed item is checked: by the filter model, no result at all,
    // or a fixed value typed into the table.
    typedef enum logic [1:0] {
        EXP_PRED,
        EXP_NONE,
        EXP_VALUE
    } plan_check_t;

    typedef struct {
        plan_kind_t           kind;
        bf3zp_pkg::cfg_reg_t  reg_sel;
        cfg_word_t            reg_val;
        pix_t                 pix;
        logic                 drn;
        plan_check_t          chk;
        pix_t                 want_value;
        logic                 want_last;
    } plan_row_t;

    // One filtered pixel as it leaves the block.
    typedef struct packed {
        pix_t value;
        logic last;
    } box_px_t;

    localparam int PLAN_ROWS   = 30;
    localparam int RANDOM_ITEMS = 1900;
    localparam int WIDE_ITEMS  = 24;    // row-zero items of a 4096-wide frame
    localparam int SETTLE_MAX  = 20000; // bound on waiting for results to drain
    localparam int QUIET_CYCLES = 10;   // pipeline is three stages deep

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            cfg_we = 1'b0;
    logic [bf3zp_pkg::CFG_IDX_W-1:0] cfg_addr = '0;
    cfg_word_t                       cfg_wdata = '0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [7:0]                      s_tdata = '0;     // [7:0] pixel
    logic                            s_tuser = 1'b0;   // [0] drain
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    logic [7:0]                      m_tdata;          // [7:0] value
    logic                            m_tlast;

    box_filter_3x3_zero_pad_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Filter model state: its own copy of the registers, line stores,
    // window and raster position.
    // ------------------------------------------------------------------
    logic [bf3zp_pkg::SIZE_W-1:0]   size_reg;
    logic [bf3zp_pkg::WEIGHT_W-1:0] weight_reg;
    logic [7:0]          row_one_up [bf3zp_pkg::DEFAULT_MAX_SIZE];
    logic [7:0]          row_two_up [bf3zp_pkg::DEFAULT_MAX_SIZE];
    logic [7:0]          win [9];
    int unsigned         pos_row;
    int unsigned         pos_col;

    box_px_t pending_px [$];   // filtered pixels still owed by the block
    box_px_t head_px;
    int      mismatches = 0;
    int      tx_idle_pct = 32;
    int      rx_idle_pct = 64;

    // Side of the square frame after clamping to [3, 4096].
    function automatic int unsigned frame_side();
        if (size_reg < bf3zp_pkg::MIN_SIZE)
            return bf3zp_pkg::MIN_SIZE;
        if (size_reg > bf3zp_pkg::DEFAULT_MAX_SIZE)
            return bf3zp_pkg::DEFAULT_MAX_SIZE;
        return size_reg;
    endfunction

    // Advance the model by one accepted item; returns 1 when a filtered
    // pixel comes out of it.
    function automatic bit box_filter_step(input logic [7:0] pix, input logic drn,
                                           output box_px_t res);
        int unsigned s;
        int unsigned r;
        int unsigned c;
        int unsigned sum;
        int unsigned scaled;
        logic [7:0]  top;
        logic [7:0]  mid;
        logic [7:0]  bot;
        bit          emit;
        bit          lst;
        s = frame_side();
        // stale position (only after odd size changes): start a new frame
        if (pos_col >= s || pos_row > s + 1 || (pos_row == s + 1 && pos_col != 0))
        begin
            pos_row = 0;
            pos_col = 0;
        end
        r = pos_row;
        c = pos_col;
        // rows above the frame and the drain rows read as zero padding
        top = (r >= 2) ? row_two_up[c] : 8'd0;
        mid = (r >= 1) ? row_one_up[c] : 8'd0;
        bot = (!drn && r < s) ? pix : 8'd0;
        row_two_up[c] = mid;
        row_one_up[c] = bot;
        for (int k = 0; k < 3; k++)
        begin
            win[k * 3]     = win[k * 3 + 1];
            win[k * 3 + 1] = win[k * 3 + 2];
        end
        win[2] = top;
        win[5] = mid;
        win[8] = bot;

        emit = (r == 1 && c >= 1) || (r >= 2 && r <= s) || (r == s + 1 && c == 0);
        lst  = (r == s + 1 && c == 0);

        // column 0 has no left neighbor, the column after the last is padding
        sum = 0;
        if (emit)
        begin
            for (int k = 0; k < 3; k++)
            begin
                if (c != 1)
                    sum += win[k * 3];
                sum += win[k * 3 + 1];
                if (c != 0)
                    sum += win[k * 3 + 2];
            end
        end

        if (lst)
        begin
            pos_row = 0;
            pos_col = 0;
        end
        else if (c + 1 >= s)
        begin
            pos_col = 0;
            pos_row = r + 1;
        end
        else
        begin
            pos_col = c + 1;
        end

        scaled = (sum * weight_reg) >> bf3zp_pkg::FRAC_W;
        if (scaled > 255)
            scaled = 255;
        res.value = scaled[7:0];
        res.last  = lst;
        return emit;
    endfunction

    // One register write; the cycle after it is left without a write so
    // cfg_we never gets two assignments in one step.
    task automatic write_reg(input bf3zp_pkg::cfg_reg_t idx, input cfg_word_t val);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        if (idx == bf3zp_pkg::REG_IMAGE_SIZE)
        begin
            size_reg = val[bf3zp_pkg::SIZE_W-1:0];
            pos_row  = 0;
            pos_col  = 0;
        end
        else
        begin
            weight_reg = val[bf3zp_pkg::WEIGHT_W-1:0];
        end
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // Offer one item, with random sender gaps first; returns at the edge
    // where it is taken.
    task automatic send_item(input logic [7:0] pix, input logic drn);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= pix;
        s_tuser  <= drn;
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    // Stop sending, let every owed pixel arrive, then give items that make
    // no result time to leave the pipeline before a register write.
    task automatic settle();
        int n;
        s_tvalid <= 1'b0;
        n = 0;
        while (pending_px.size() != 0 && n < SETTLE_MAX)
        begin
            @(posedge clk);
            n++;
        end
        repeat (QUIET_CYCLES) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Receiver: random stalls and the result check.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        m_tready <= ($urandom_range(99) >= rx_idle_pct);
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_px.size() == 0)
            begin
                $error("value: expected no item, got %0d (last %0b)", m_tdata, m_tlast);
                mismatches++;
            end
            else
            begin
                head_px = pending_px.pop_front();
                if (m_tdata !== head_px.value)
                begin
                    $error("value: expected %0d, got %0d", head_px.value, m_tdata);
                    mismatches++;
                end
                if (m_tlast !== head_px.last)
                begin
                    $error("last: expected %0b, got %0b", head_px.last, m_tlast);
                    mismatches++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Directed plan. Frame A: size below the minimum (acts as 3) and the
    // largest weight, so every output saturates; includes a pixel sent
    // during the drain rows. Frame B: zero weight, a drain during the
    // pixel rows; cut short by a size write in C, which restarts the frame.
    // ------------------------------------------------------------------
    plan_row_t plan [PLAN_ROWS] = '{
        '{ROW_CFG,  bf3zp_pkg::REG_IMAGE_SIZE, 15'd0,     8'h00, 1'b0, EXP_NONE,  8'h00, 1'b0},
        '{ROW_CFG,  bf3zp_pkg::REG_TAP_WEIGHT, 15'd32767, 8'h00, 1'b0, EXP_NONE,  8'h00, 1'b0},
        '{ROW_ITEM, bf3zp_pkg::REG_IMAGE_SIZE, 15'd0,     8'hFF, 1'b0, EXP_NONE,  8'h00, 1'b0},
        '{ROW_ITEM, bf3zp_pkg::REG_IMAGE_SIZE, 15'd0,     8'hFF, 1'b0, EXP_NONE,  8'h00, 1'b0},
        '{ROW_ITEM, bf3zp_pkg::REG_IMAGE_SIZE, 15'd0,     8'hFF, 1'b0, EXP_NONE,  8'h00, 1'b0},
        '{ROW_ITEM, bf3zp_pkg::REG_IMAGE_SIZE, 15'd0,     8'hFF, 1'b0, EXP_NONE,  8'h00, 1'b0},
        '{ROW_ITEM, bf3zp_pkg::REG_IMAGE_SIZE, 15'd0,     8'hFF, 1'b0, EXP_VALUE, 8'hFF, 1'b0},
        '{ROW_ITEM, bf3zp_pkg::REG_IMAGE_SIZE, 15'd0,     8'hFF, 1'b0, EXP_VALUE, 8'hFF, 1'b0},
        '{ROW_ITEM, bf3zp_pkg::REG_IMAGE_SIZE, 15'd0,     8'hFF, 1'b0, EXP_VALUE, 8'hFF, 1'b0},
        '{ROW_ITEM, bf3zp_pkg::REG_IMAGE_SIZE, 15'd0,     8'hFF, 1'b0, EXP_VALUE, 8'hFF, 1'b0},
        '{ROW_ITEM, bf3zp_pkg::REG_IMAGE_SIZE, 15'd0,     8'hFF, 1'b0, EXP_VALUE, 8'hFF, 1'b0},
        '{ROW_ITEM, bf3zp_pkg::REG_IMAGE_SIZE, 15'd0,     8'h00, 1'b1, EXP_VALUE, 8'hFF, 1'b0},
        '{ROW_ITEM, bf3zp_pkg::REG_IMAGE_SIZE, 15'd0,     8'hAA, 1'b0, EXP_VALUE, 8'hFF, 1'b0},
        '{ROW_ITEM, bf3zp_pkg::REG_IMAGE_SIZE, 15'd0,     8'h00, 1'b1, EXP_VALUE, 8'hFF, 1'b0},
        '{ROW_ITEM, bf3zp_pkg::REG_IMAGE_SIZE, 15'd0,     8'h00, 1'b1, EXP_VALUE, 8'hFF, 1'b1},
        '{ROW_CFG,  bf3zp_pkg::REG_TAP_WEIGHT, 15'd0,     8'h00, 1'b0, EXP_NONE,  8'h00, 1'b0},
        '{ROW_ITEM, bf3zp_pkg::REG_IMAGE_SIZE, 15'd0,     8'h00, 1'b0, EXP_NONE,  8'h00, 1'b0},
        '{ROW_ITEM, bf3zp_pkg::REG_IMAGE_SIZE, 15'd0,     8'hFF, 1'b0, EXP_NONE,  8'h00, 1'b0},
        '{ROW_ITEM, bf3zp_pkg::REG_IMAGE_SIZE, 15'd0,     8'h77, 1'b1, EXP_NONE,  8'h00, 1'b0},
        '{ROW_ITEM, bf3zp_pkg::REG_IMAGE_SIZE, 15'd0,     8'h5A, 1'b0, EXP_NONE,  8'h00, 1'b0},
        '{ROW_ITEM, bf3zp_pkg::REG_IMAGE_SIZE, 15'd0,     8'h0F, 1'b0, EXP_VALUE, 8'h00, 1'b0},
        '{ROW_ITEM, bf3zp_pkg::REG_IMAGE_SIZE, 15'd0,     8'hF0, 1'b0, EXP_VALUE, 8'h00, 1'b0},
        '{ROW_CFG,  bf3zp_pkg::REG_IMAGE_SIZE, 15'd4,     8'h00, 1'b0, EXP_NONE,  8'h00, 1'b0},
        '{ROW_CFG,  bf3zp_pkg::REG_TAP_WEIGHT, 15'd3641,  8'h00, 1'b0, EXP_NONE,  8'h00, 1'b0},
        '{ROW_ITEM, bf3zp_pkg::REG_IMAGE_SIZE, 15'd0,     8'h12, 1'b0, EXP_PRED,  8'h00, 1'b0},
        '{ROW_ITEM, bf3zp_pkg::REG_IMAGE_SIZE, 15'd0,     8'h34, 1'b0, EXP_PRED,  8'h00, 1'b0},
        '{ROW_ITEM, bf3zp_pkg::REG_IMAGE_SIZE, 15'd0,     8'h56, 1'b0, EXP_PRED,  8'h00, 1'b0},
        '{ROW_ITEM, bf3zp_pkg::REG_IMAGE_SIZE, 15'd0,     8'h78, 1'b0, EXP_PRED,  8'h00, 1'b0},
        '{ROW_ITEM, bf3zp_pkg::REG_IMAGE_SIZE, 15'd0,     8'h9A, 1'b0, EXP_PRED,  8'h00, 1'b0},
        '{ROW_ITEM, bf3zp_pkg::REG_IMAGE_SIZE, 15'd0,     8'hBC, 1'b0, EXP_PRED,  8'h00, 1'b0}
    };

    // ------------------------------------------------------------------
    // Stimulus: reset, directed plan, then random phases of mostly whole
    // frames with a little noise, then the verdict.
    // ------------------------------------------------------------------
    initial
    begin : stim
        box_px_t          got;
        bit               emitted;
        logic [7:0]       pix;
        logic             drn;
        cfg_word_t        val;
        int unsigned      random_items;
        int unsigned      s;
        int unsigned      len;
        int unsigned      frames;
        int unsigned      pick;
        int unsigned      roll;
        bit               wide_done;

        // model after reset; line stores zeroed though never read unwritten
        size_reg   = bf3zp_pkg::SIZE_RESET;
        weight_reg = bf3zp_pkg::WEIGHT_RESET;
        pos_row    = 0;
        pos_col    = 0;
        for (int i = 0; i < bf3zp_pkg::DEFAULT_MAX_SIZE; i++)
        begin
            row_one_up[i] = 8'd0;
            row_two_up[i] = 8'd0;
        end
        for (int i = 0; i < 9; i++)
            win[i] = 8'd0;
        random_items = 0;
        wide_done    = 1'b0;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part, checked under sender 32 / receiver 64 idling
        foreach (plan[i])
        begin
            if (plan[i].kind == ROW_CFG)
            begin
                settle();
                write_reg(plan[i].reg_sel, plan[i].reg_val);
            end
            else
            begin
                send_item(plan[i].pix, plan[i].drn);
                emitted = box_filter_step(plan[i].pix, plan[i].drn, got);
                if (plan[i].chk == EXP_PRED && emitted)
                    pending_px.push_back(got);
                else if (plan[i].chk == EXP_VALUE)
                    pending_px.push_back(box_px_t'{value: plan[i].want_value,
                                                   last: plan[i].want_last});
            end
        end

        while (random_items < RANDOM_ITEMS)
        begin
            // idling schedule: sender light / receiver heavy, swapped, none
            if (random_items < RANDOM_ITEMS / 3)
            begin
                tx_idle_pct = 32;
                rx_idle_pct = 64;
            end
            else if (random_items < 2 * RANDOM_ITEMS / 3)
            begin
                tx_idle_pct = 64;
                rx_idle_pct = 32;
            end
            else
            begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end

            // one pass at the largest size: all 15 data bits set, masked to
            // 8191 and clamped to 4096; a short run of row-zero pixels that
            // makes no result
            if (!wide_done && random_items >= RANDOM_ITEMS / 2)
            begin
                wide_done = 1'b1;
                settle();
                write_reg(bf3zp_pkg::REG_IMAGE_SIZE, 15'h7FFF);
                for (int n = 0; n < WIDE_ITEMS; n++)
                begin
                    pix = pix_t'($urandom_range(255));
                    send_item(pix, 1'b0);
                    if (box_filter_step(pix, 1'b0, got))
                        pending_px.push_back(got);
                    random_items++;
                end
            end

            settle();
            pick = $urandom_range(3);
            // always leave the wide size behind before whole frames
            if (pick != 1 || frame_side() > 16)
            begin
                roll = $urandom_range(99);
                if (roll < 8)
                    val = cfg_word_t'($urandom_range(2));        // below the minimum
                else if (roll < 16)
                    val = cfg_word_t'(bf3zp_pkg::MIN_SIZE);
                else
                    val = cfg_word_t'($urandom_range(10, 4));
                if ($urandom_range(3) == 0)
                    val[bf3zp_pkg::CFG_W-1:bf3zp_pkg::SIZE_W] = 2'($urandom_range(3));
                write_reg(bf3zp_pkg::REG_IMAGE_SIZE, val);
            end
            if (pick != 0)
            begin
                roll = $urandom_range(99);
                if (roll < 10)
                    val = 15'd0;
                else if (roll < 20)
                    val = 15'd32767;
                else if (roll < 40)
                    val = bf3zp_pkg::WEIGHT_RESET;
                else
                    val = cfg_word_t'($urandom_range(32767));
                write_reg(bf3zp_pkg::REG_TAP_WEIGHT, val);
            end

            s = frame_side();
            frames = $urandom_range(3, 1);
            for (int f = 0; f < frames; f++)
            begin
                len = s * s + s + 1;
                // sometimes the last frame is cut off; the next size write
                // restarts it
                if (f == frames - 1 && $urandom_range(99) < 20)
                    len = $urandom_range(len - 1, 1);
                for (int n = 0; n < len; n++)
                begin
                    pix = pix_t'($urandom_range(255));
                    if (n < s * s)
                        drn = ($urandom_range(99) < 4);     // stray drain
                    else
                        drn = ($urandom_range(99) >= 15);   // stray pixel
                    send_item(pix, drn);
                    if (box_filter_step(pix, drn, got))
                        pending_px.push_back(got);
                    random_items++;
                end
            end
        end

        settle();
        if (pending_px.size() != 0)
        begin
            $error("value: %0d items still expected at the end", pending_px.size());
            mismatches++;
        end
        if (mismatches == 0)
            $display("[box_filter_3x3_zero_pad_top] OK");
        else
            $display("[box_filter_3x3_zero_pad_top] ERROR");
        $finish;
    end

    // hard stop if the block hangs
    initial
    begin
        #5ms;
        $display("[box_filter_3x3_zero_pad_top] ERROR");
        $finish;
    end

endmodule
